// ===== rtl/sob_pkg.sv =====
// Shared types and constants for the Sobol point generator.
package sob_pkg;

	localparam int MAX_BITS_DEF   = 32;
	localparam int MAX_DEGREE_DEF = 8;
	localparam int M_COUNT        = 8;

	localparam int VAL_W   = 32;
	localparam int IDX_W   = 31;
	localparam int DEG_W   = 4;
	localparam int COEF_W  = 7;
	localparam int DIR_W   = 64;
	localparam int CFG_A_W = 2;

	localparam logic [CFG_A_W-1:0] REG_POLY_DEGREE  = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_POLY_COEFF   = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_INIT_DIRS    = 2'd2;
	localparam logic [CFG_A_W-1:0] REG_TOTAL_POINTS = 2'd3;

	localparam logic [DEG_W-1:0]  POLY_DEGREE_RST  = '0;
	localparam logic [COEF_W-1:0] POLY_COEFF_RST   = '0;
	localparam logic [DIR_W-1:0]  INIT_DIRS_RST    = 64'h0101_0101_0101_0101;
	localparam logic [IDX_W-1:0]  TOTAL_POINTS_RST = 31'd1024;

	// Direction table status seen by the point stepper.
	typedef struct packed {
		logic ready;  // table holds a complete build
		logic done;   // registered pulse, set by the same edge that writes the last entry
	} tbl_status_t;

endpackage

// ===== rtl/sob_dir_table.sv =====
// Direction number table: one-entry-per-cycle build and read port.
module sob_dir_table
	import sob_pkg::*;
#(
	parameter int MAX_BITS   = MAX_BITS_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF,
	localparam int TBL_AW    = $clog2(MAX_BITS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rebuild,
	input  logic [DEG_W-1:0]  poly_degree,
	input  logic [COEF_W-1:0] poly_coeff_bits,
	input  logic [DIR_W-1:0]  initial_directions,
	input  logic [TBL_AW-1:0] rd_idx,
	output logic [VAL_W-1:0]  rd_data,
	output tbl_status_t       status
);

	localparam int DEG_LIM = (MAX_DEGREE < M_COUNT) ? MAX_DEGREE : M_COUNT;

	logic [VAL_W-1:0]  tbl_q [MAX_BITS];
	logic [VAL_W-1:0]  hist_q [DEG_LIM];  // hist_q[j] is V(i-1-j)
	logic [TBL_AW-1:0] bidx_q;
	logic              ready_q;
	logic              done_q;

	logic [DEG_W-1:0]  s_eff;
	logic [7:0]        m_sel;
	logic [VAL_W-1:0]  back;
	logic [VAL_W-1:0]  new_v;
	logic              last_entry;

	assign s_eff = (poly_degree > DEG_W'(DEG_LIM)) ? DEG_W'(DEG_LIM) : poly_degree;
	assign m_sel = initial_directions[{bidx_q[2:0], 3'b000} +: 8];
	assign last_entry = (bidx_q == TBL_AW'(MAX_BITS - 1));

	always_comb begin
		back = '0;
		for (int j = 0; j < DEG_LIM; j++) begin
			if (int'(s_eff) == j + 1) begin
				back = hist_q[j];
			end
		end
		if (s_eff == '0) begin
			new_v = 32'h8000_0000 >> bidx_q;
		end else if (int'(bidx_q) < int'(s_eff)) begin
			new_v = {24'b0, m_sel} << (5'd31 - 5'(bidx_q));
		end else begin
			new_v = back ^ (back >> s_eff);
			for (int k = 1; k < DEG_LIM; k++) begin
				for (int b = 0; b < COEF_W; b++) begin
					// coefficient bit s-1-k weights V(i-k)
					if (int'(s_eff) == b + 1 + k && poly_coeff_bits[b]) begin
						new_v = new_v ^ hist_q[k-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			done_q  <= 1'b0;
			bidx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (rebuild) begin
				ready_q <= 1'b0;
				bidx_q  <= '0;
			end else if (!ready_q) begin
				if (last_entry) begin
					ready_q <= 1'b1;
					done_q  <= 1'b1;
					bidx_q  <= '0;
				end else begin
					bidx_q <= bidx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ready_q && !rebuild) begin
			tbl_q[bidx_q] <= new_v;
			hist_q[0]     <= new_v;
			for (int j = 1; j < DEG_LIM; j++) begin
				hist_q[j] <= hist_q[j-1];
			end
		end
	end

	assign rd_data      = tbl_q[rd_idx];
	assign status.ready = ready_q;
	assign status.done  = done_q;

endmodule

// ===== rtl/sob_stepper.sv =====
// Point stepper: Gray-code index advance, running value and result register.
module sob_stepper
	import sob_pkg::*;
#(
	parameter int MAX_BITS = MAX_BITS_DEF,
	localparam int TBL_AW  = $clog2(MAX_BITS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tbl_status_t       status,
	input  logic [IDX_W-1:0]  total_points,
	output logic [TBL_AW-1:0] rd_idx,
	input  logic [VAL_W-1:0]  rd_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VAL_W-1:0]  point_value,
	output logic [IDX_W-1:0]  point_index,
	output logic              last_point
);

	logic [VAL_W-1:0] running_q;
	logic [IDX_W-1:0] next_index_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] point_value_q;
	logic [IDX_W-1:0] point_index_q;
	logic             last_point_q;

	logic [VAL_W-1:0] cur_val;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] count_m1;
	logic [4:0]       tones;
	logic             hit;
	logic             accept;

	// count of trailing ones, all ones gives the full width
	always_comb begin
		tones = 5'(IDX_W);
		for (int j = IDX_W - 1; j >= 0; j--) begin
			if (!cur_idx[j]) begin
				tones = 5'(j);
			end
		end
	end

	assign cur_idx  = restart ? '0 : next_index_q;
	assign cur_val  = restart ? '0 : running_q;
	assign count_m1 = (total_points == '0) ? '0 : total_points - 1'b1;
	assign hit      = (int'(tones) < MAX_BITS);
	assign rd_idx   = tones[TBL_AW-1:0];
	// no item in the cycle the sequence state is cleared after a build
	assign in_ready = status.ready && !status.done && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= '0;
			next_index_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (status.done) begin
				running_q    <= '0;
				next_index_q <= '0;
			end else if (accept) begin
				if (cur_idx >= count_m1) begin
					running_q    <= '0;
					next_index_q <= '0;
				end else begin
					running_q    <= cur_val ^ (hit ? rd_data : '0);
					next_index_q <= cur_idx + 1'b1;
				end
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			point_value_q <= cur_val;
			point_index_q <= cur_idx;
			last_point_q  <= (cur_idx == count_m1);
		end
	end

	assign out_valid   = out_valid_q;
	assign point_value = point_value_q;
	assign point_index = point_index_q;
	assign last_point  = last_point_q;

endmodule

// ===== rtl/sobol_point_generator.sv =====
// Sobol point generator (one dimension, Gray-code order): top level.
// An accepted item's point is loaded into the result register by the edge that accepts it.
// Throughput: 1 point per cycle; a new item is taken in the cycle a waiting result leaves.
// Table build: one entry per cycle, then a clear of the sequence state; it runs
// after reset and after a write of poly_degree, poly_coeff_bits or initial_directions.
// in_ready is low during a build. Reset (arst_n, async, active low) restores the registers.
module sobol_point_generator
	import sob_pkg::*;
#(
	parameter int MAX_BITS   = MAX_BITS_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_A_W-1:0] cfg_index,
	input  logic [DIR_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VAL_W-1:0]   point_value,
	output logic [IDX_W-1:0]   point_index,
	output logic               last_point
);

	localparam int TBL_AW = $clog2(MAX_BITS);

	logic [DEG_W-1:0]  poly_degree_q;
	logic [COEF_W-1:0] poly_coeff_q;
	logic [DIR_W-1:0]  init_dirs_q;
	logic [IDX_W-1:0]  total_points_q;
	logic              cfg_wr;
	logic              rebuild;
	logic [TBL_AW-1:0] rd_idx;
	logic [VAL_W-1:0]  rd_data;
	tbl_status_t       status;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		rebuild = 1'b0;
		if (cfg_wr) begin
			case (cfg_index)
				REG_POLY_DEGREE, REG_POLY_COEFF, REG_INIT_DIRS: rebuild = 1'b1;
				default: rebuild = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_degree_q  <= POLY_DEGREE_RST;
			poly_coeff_q   <= POLY_COEFF_RST;
			init_dirs_q    <= INIT_DIRS_RST;
			total_points_q <= TOTAL_POINTS_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_POLY_DEGREE:  poly_degree_q  <= cfg_data[DEG_W-1:0];
				REG_POLY_COEFF:   poly_coeff_q   <= cfg_data[COEF_W-1:0];
				REG_INIT_DIRS:    init_dirs_q    <= cfg_data;
				REG_TOTAL_POINTS: total_points_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	sob_dir_table #(
		.MAX_BITS   (MAX_BITS),
		.MAX_DEGREE (MAX_DEGREE)
	) u_table (
		.clk                (clk),
		.arst_n             (arst_n),
		.rebuild            (rebuild),
		.poly_degree        (poly_degree_q),
		.poly_coeff_bits    (poly_coeff_q),
		.initial_directions (init_dirs_q),
		.rd_idx             (rd_idx),
		.rd_data            (rd_data),
		.status             (status)
	);

	sob_stepper #(
		.MAX_BITS (MAX_BITS)
	) u_stepper (
		.clk          (clk),
		.arst_n       (arst_n),
		.status       (status),
		.total_points (total_points_q),
		.rd_idx       (rd_idx),
		.rd_data      (rd_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_value  (point_value),
		.point_index  (point_index),
		.last_point   (last_point)
	);

`ifndef ASSERT_OFF
	a_accept_needs_table: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> status.ready)
		else $error("item accepted before direction table was built");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted item produced no result");

	a_poly_write_rebuilds: assert property (@(posedge clk) disable iff (!arst_n)
		rebuild |=> (!status.ready && !in_ready))
		else $error("polynomial write did not start a table build");
`endif

endmodule
